// ----- design/hbp_pkg.sv -----
// shared types, constants and a helper function of the hybrid branch predictor
`default_nettype none

package hbp_pkg;

    // table sizes
    localparam int GS_BITS_MAX = 12;
    localparam int BI_BITS_MAX = 12;
    localparam int CH_BITS_MAX = 12;
    localparam int GS_CNT_W = $clog2(GS_BITS_MAX + 1);
    localparam int BI_CNT_W = $clog2(BI_BITS_MAX + 1);
    localparam int CH_CNT_W = $clog2(CH_BITS_MAX + 1);
    localparam int CLR_BITS_GB = (GS_BITS_MAX > BI_BITS_MAX) ? GS_BITS_MAX : BI_BITS_MAX;
    localparam int CLR_BITS = (CLR_BITS_GB > CH_BITS_MAX) ? CLR_BITS_GB : CH_BITS_MAX;

    // 2-bit saturating counters
    localparam int CTR_W = 2;
    localparam logic [CTR_W-1:0] CTR_MAX = 2'd3;
    localparam logic [CTR_W-1:0] CTR_WEAK_T = 2'd2;
    localparam logic [CTR_W-1:0] CTR_CH_RST = 2'd1;

    // predictor kinds
    localparam logic [1:0] MODE_BIMODAL = 2'd0;
    localparam logic [1:0] MODE_GSHARE = 2'd1;
    localparam logic [1:0] MODE_HYBRID = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GS_BITS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIST_BITS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BI_BITS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CH_BITS = 3'd4;

    typedef struct packed {
        logic [31:0] pc;
        logic        taken;
    } in_req_t;

    typedef struct packed {
        logic        predicted_taken;
        logic        mispredicted;
        logic        used_gshare;
        logic [31:0] branch_count;
        logic [31:0] miss_count;
    } out_rsp_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [3:0] gs_bits;
        logic [3:0] hist_bits;
        logic [3:0] bi_bits;
        logic [3:0] ch_bits;
    } cfg_t;

    typedef struct packed {
        logic [BI_BITS_MAX-1:0] bi;
        logic [GS_BITS_MAX-1:0] gs;
        logic [CH_BITS_MAX-1:0] ch;
        logic [GS_CNT_W-1:0]    hlen;
    } idx_t;

    typedef struct packed {
        logic             pred;
        logic             used_gs;
        logic             shift_hist;
        logic             bi_we;
        logic             gs_we;
        logic             ch_we;
        logic [CTR_W-1:0] bi_new;
        logic [CTR_W-1:0] gs_new;
        logic [CTR_W-1:0] ch_new;
    } upd_t;

    // saturating counter step
    function automatic logic [CTR_W-1:0] ctr_train(input logic [CTR_W-1:0] c, input logic t);
        logic [CTR_W-1:0] r;
        if (t)
            r = (c == CTR_MAX) ? c : c + 1'b1;
        else
            r = (c == '0) ? c : c - 1'b1;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/hbp_ram.sv -----
// single-port-write, single-port-read synchronous ram with registered read data
`default_nettype none

module hbp_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 2
) (
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- design/hbp_index.sv -----
// table index and history length computation from pc, history and configuration
`default_nettype none

module hbp_index
    import hbp_pkg::*;
(
    input  wire logic [31:0]          pc,
    input  wire logic [GS_BITS_MAX-1:0] hist,
    input  wire cfg_t                 cfg,
    output idx_t                      idx
);

    logic [GS_CNT_W-1:0]    m1;
    logic [BI_CNT_W-1:0]    m2;
    logic [CH_CNT_W-1:0]    k;
    logic [GS_CNT_W-1:0]    n;
    logic [GS_BITS_MAX-1:0] gs_mask;
    logic [GS_BITS_MAX-1:0] hist_mask;
    logic [GS_BITS_MAX-1:0] hist_sh;
    logic [BI_BITS_MAX-1:0] bi_mask;
    logic [CH_BITS_MAX-1:0] ch_mask;

    // clamp widths to the table sizes, history to the gshare width
    always_comb
    begin
        m1 = (int'(cfg.gs_bits) > GS_BITS_MAX) ? GS_CNT_W'(GS_BITS_MAX)
                                               : GS_CNT_W'(cfg.gs_bits);
        m2 = (int'(cfg.bi_bits) > BI_BITS_MAX) ? BI_CNT_W'(BI_BITS_MAX)
                                               : BI_CNT_W'(cfg.bi_bits);
        k  = (int'(cfg.ch_bits) > CH_BITS_MAX) ? CH_CNT_W'(CH_BITS_MAX)
                                               : CH_CNT_W'(cfg.ch_bits);
        n  = (int'(cfg.hist_bits) > int'(m1)) ? m1 : GS_CNT_W'(cfg.hist_bits);
    end

    // low-bit masks
    assign gs_mask   = ~({GS_BITS_MAX{1'b1}} << m1);
    assign hist_mask = ~({GS_BITS_MAX{1'b1}} << n);
    assign bi_mask   = ~({BI_BITS_MAX{1'b1}} << m2);
    assign ch_mask   = ~({CH_BITS_MAX{1'b1}} << k);

    // history aligned to the top of the gshare index
    assign hist_sh = (hist & hist_mask) << (m1 - n);

    always_comb
    begin
        idx.bi   = pc[2 +: BI_BITS_MAX] & bi_mask;
        idx.ch   = pc[2 +: CH_BITS_MAX] & ch_mask;
        idx.gs   = (pc[2 +: GS_BITS_MAX] ^ hist_sh) & gs_mask;
        idx.hlen = n;
    end

endmodule

`default_nettype wire

// ----- design/hbp_train.sv -----
// prediction selection and counter training for one resolved branch
`default_nettype none

module hbp_train
    import hbp_pkg::*;
(
    input  wire logic [1:0]       mode,
    input  wire logic             taken,
    input  wire logic [CTR_W-1:0] bi_ctr,
    input  wire logic [CTR_W-1:0] gs_ctr,
    input  wire logic [CTR_W-1:0] ch_ctr,
    output upd_t                  upd
);

    logic p_bi;
    logic p_gs;
    logic sel_gs;

    assign p_bi   = (bi_ctr >= CTR_WEAK_T);
    assign p_gs   = (gs_ctr >= CTR_WEAK_T);
    assign sel_gs = (ch_ctr >= CTR_WEAK_T);

    // pick the predictor and the tables to train
    always_comb
    begin
        upd.bi_new     = ctr_train(bi_ctr, taken);
        upd.gs_new     = ctr_train(gs_ctr, taken);
        upd.ch_new     = ctr_train(ch_ctr, p_gs == taken);
        upd.pred       = p_bi;
        upd.used_gs    = 1'b0;
        upd.shift_hist = 1'b0;
        upd.bi_we      = 1'b0;
        upd.gs_we      = 1'b0;
        upd.ch_we      = 1'b0;
        case (mode)
            MODE_GSHARE:
            begin
                upd.pred       = p_gs;
                upd.gs_we      = 1'b1;
                upd.shift_hist = 1'b1;
            end
            MODE_HYBRID:
            begin
                upd.used_gs    = sel_gs;
                upd.pred       = sel_gs ? p_gs : p_bi;
                upd.gs_we      = sel_gs;
                upd.bi_we      = !sel_gs;
                upd.shift_hist = 1'b1;
                // chooser moves only when exactly one predictor was right
                upd.ch_we      = (p_gs != p_bi);
            end
            default:
            begin
                upd.bi_we = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/hybrid_branch_predictor.sv -----
// top level of the bimodal / gshare / hybrid branch predictor
//
// Usage: each request on the input channel (in_valid, in_stall, in_req) is one
// resolved branch: its pc and actual direction. Each request yields exactly one
// response on the output channel (out_valid, out_stall, out_rsp): the prediction
// made before training, the mispredict flag, the chooser pick in hybrid mode and
// saturating branch and miss counts.
// The counter tables are synchronous rams read in the accept cycle into their
// read registers and written back as the response enters the output register,
// which waits while the output stalls; no new request is taken until then, so
// the next request waits for that write and the history update.
// Reset: the three counter tables are cleared by a pass over all 4096 entries
// (one entry per table per cycle); in_stall stays high during that pass.
// Configuration writes through cfg_we, cfg_index, cfg_data are taken at any
// time but must only be issued while the block is idle.
// When the receiver stalls, the response is held in the output register; one
// more request is still accepted and then waits in the update stage.
`default_nettype none

module hybrid_branch_predictor
    import hbp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_req_t               in_req,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_rsp_t                   out_rsp,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_BUSY  = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [CLR_BITS-1:0]    clr_cnt_reg;
    cfg_t                   cfg_reg;
    logic [GS_BITS_MAX-1:0] hist_reg, hist_next;
    logic [31:0]            branch_cnt_reg, branch_cnt_next;
    logic [31:0]            miss_cnt_reg, miss_cnt_next;
    idx_t                   idx_reg;
    logic                   taken_reg;
    logic                   out_valid_reg;
    out_rsp_t               out_reg;

    idx_t                   idx;
    upd_t                   upd;
    logic                   clearing;
    logic                   in_acc;
    logic                   done;
    logic                   pred_miss;
    logic [CTR_W-1:0]       bi_rd, gs_rd, ch_rd;
    logic                   bi_we, gs_we, ch_we;
    logic [BI_BITS_MAX-1:0] bi_wa;
    logic [GS_BITS_MAX-1:0] gs_wa;
    logic [CH_BITS_MAX-1:0] ch_wa;
    logic [CTR_W-1:0]       bi_wd, gs_wd, ch_wd;
    logic [GS_BITS_MAX-1:0] hist_m;

    // handshake
    assign clearing  = (state_reg == ST_CLEAR);
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign done      = (state_reg == ST_BUSY) && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_rsp   = out_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode      <= MODE_BIMODAL;
            cfg_reg.gs_bits   <= 4'd12;
            cfg_reg.hist_bits <= 4'd8;
            cfg_reg.bi_bits   <= 4'd12;
            cfg_reg.ch_bits   <= 4'd12;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:      cfg_reg.mode      <= cfg_data[1:0];
                REG_GS_BITS:   cfg_reg.gs_bits   <= cfg_data;
                REG_HIST_BITS: cfg_reg.hist_bits <= cfg_data;
                REG_BI_BITS:   cfg_reg.bi_bits   <= cfg_data;
                REG_CH_BITS:   cfg_reg.ch_bits   <= cfg_data;
                default:       ;
            endcase
        end
    end

    // index computation at accept
    hbp_index u_index (
        .pc   (in_req.pc),
        .hist (hist_reg),
        .cfg  (cfg_reg),
        .idx  (idx)
    );

    // counter tables
    hbp_ram #(.ADDR_W(BI_BITS_MAX), .DATA_W(CTR_W)) u_bi_ram (
        .clk     (clk),
        .rd_en   (in_acc),
        .rd_addr (idx.bi),
        .rd_data (bi_rd),
        .wr_en   (bi_we),
        .wr_addr (bi_wa),
        .wr_data (bi_wd)
    );

    hbp_ram #(.ADDR_W(GS_BITS_MAX), .DATA_W(CTR_W)) u_gs_ram (
        .clk     (clk),
        .rd_en   (in_acc),
        .rd_addr (idx.gs),
        .rd_data (gs_rd),
        .wr_en   (gs_we),
        .wr_addr (gs_wa),
        .wr_data (gs_wd)
    );

    hbp_ram #(.ADDR_W(CH_BITS_MAX), .DATA_W(CTR_W)) u_ch_ram (
        .clk     (clk),
        .rd_en   (in_acc),
        .rd_addr (idx.ch),
        .rd_data (ch_rd),
        .wr_en   (ch_we),
        .wr_addr (ch_wa),
        .wr_data (ch_wd)
    );

    // prediction and training
    hbp_train u_train (
        .mode   (cfg_reg.mode),
        .taken  (taken_reg),
        .bi_ctr (bi_rd),
        .gs_ctr (gs_rd),
        .ch_ctr (ch_rd),
        .upd    (upd)
    );

    // write-back or clearing pass
    always_comb
    begin
        bi_we = clearing || (done && upd.bi_we);
        gs_we = clearing || (done && upd.gs_we);
        ch_we = clearing || (done && upd.ch_we);
        bi_wa = clearing ? clr_cnt_reg[BI_BITS_MAX-1:0] : idx_reg.bi;
        gs_wa = clearing ? clr_cnt_reg[GS_BITS_MAX-1:0] : idx_reg.gs;
        ch_wa = clearing ? clr_cnt_reg[CH_BITS_MAX-1:0] : idx_reg.ch;
        bi_wd = clearing ? CTR_WEAK_T : upd.bi_new;
        gs_wd = clearing ? CTR_WEAK_T : upd.gs_new;
        ch_wd = clearing ? CTR_CH_RST : upd.ch_new;
    end

    // global history shift
    assign hist_m = hist_reg & ~({GS_BITS_MAX{1'b1}} << idx_reg.hlen);

    always_comb
    begin
        hist_next = hist_reg;
        if (done && upd.shift_hist)
        begin
            if (idx_reg.hlen == '0)
                hist_next = '0;
            else
                hist_next = (hist_m >> 1)
                          | (GS_BITS_MAX'(taken_reg) << (idx_reg.hlen - 1'b1));
        end
    end

    // saturating statistics
    assign pred_miss = (upd.pred != taken_reg);

    always_comb
    begin
        branch_cnt_next = branch_cnt_reg;
        miss_cnt_next   = miss_cnt_reg;
        if (done)
        begin
            if (branch_cnt_reg != 32'hFFFF_FFFF)
                branch_cnt_next = branch_cnt_reg + 32'd1;
            if (pred_miss && (miss_cnt_reg != 32'hFFFF_FFFF))
                miss_cnt_next = miss_cnt_reg + 32'd1;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == {CLR_BITS{1'b1}})
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_acc)
                    state_next = ST_BUSY;
            end
            ST_BUSY:
            begin
                if (done)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            hist_reg       <= '0;
            branch_cnt_reg <= '0;
            miss_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            hist_reg       <= hist_next;
            branch_cnt_reg <= branch_cnt_next;
            miss_cnt_reg   <= miss_cnt_next;
            if (clearing)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (done)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // request and response payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            idx_reg   <= idx;
            taken_reg <= in_req.taken;
        end
        if (done)
        begin
            out_reg.predicted_taken <= upd.pred;
            out_reg.mispredicted    <= pred_miss;
            out_reg.used_gshare     <= upd.used_gs;
            out_reg.branch_count    <= branch_cnt_next;
            out_reg.miss_count      <= miss_cnt_next;
        end
    end

`ifndef SYNTHESIS
    // a request in the update stage is never dropped while the output is blocked
    a_hold_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BUSY && out_valid_reg && out_stall) |=> (state_reg == ST_BUSY))
        else $error("update stage lost a request under output stall");

    // misses never outnumber branches
    a_miss_le_branch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.miss_count <= out_reg.branch_count))
        else $error("miss count above branch count");

    // table write-back never overlaps a new read
    a_no_rmw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> !(bi_we || gs_we || ch_we))
        else $error("table write coincides with accept");

    // branch count advances by one per response
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (done && branch_cnt_reg != 32'hFFFF_FFFF) |=> (branch_cnt_reg == $past(branch_cnt_reg) + 32'd1))
        else $error("branch count did not advance");
`endif

endmodule

`default_nettype wire
